// ===== src/htp_pkg.sv =====
// ---------------------------------------------------------------------------
// htp_pkg: shared types and constants of the key/value text parser
// Beat formats, phase codes, result kinds, status codes and byte helpers.
// ---------------------------------------------------------------------------
package htp_pkg;

    // Input beat: one byte of text plus the end-of-string mark.
    typedef struct packed {
        logic [7:0] byte_req;
        logic       last;
    } t_in_beat;

    // Output beat: one result item.
    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data;
        logic       is_null;
        logic [1:0] status;
        logic       final_res;
    } t_out_beat;

    // Number of result slots one input byte can fill.
    localparam int unsigned RES_SLOTS = 3;

    typedef logic [1:0] t_res_cnt;

    // Hand-off from the parser to the result queue.
    typedef struct packed {
        logic     push;
        t_res_cnt cnt;
    } t_res_push;

    // Parse phases.
    localparam logic [3:0] PH_KEY_WAIT  = 4'd0;
    localparam logic [3:0] PH_KEY_Q     = 4'd1;
    localparam logic [3:0] PH_KEY_Q_ESC = 4'd2;
    localparam logic [3:0] PH_KEY_U     = 4'd3;
    localparam logic [3:0] PH_KEY_U_ESC = 4'd4;
    localparam logic [3:0] PH_EQ        = 4'd5;
    localparam logic [3:0] PH_GT        = 4'd6;
    localparam logic [3:0] PH_VAL_WAIT  = 4'd7;
    localparam logic [3:0] PH_VAL_Q     = 4'd8;
    localparam logic [3:0] PH_VAL_Q_ESC = 4'd9;
    localparam logic [3:0] PH_VAL_U     = 4'd10;
    localparam logic [3:0] PH_VAL_U_ESC = 4'd11;
    localparam logic [3:0] PH_DEL       = 4'd12;
    localparam logic [3:0] PH_DISCARD   = 4'd13;

    // Result kinds.
    localparam logic [2:0] K_KEY_BYTE = 3'd0;
    localparam logic [2:0] K_VAL_BYTE = 3'd1;
    localparam logic [2:0] K_KEY_END  = 3'd2;
    localparam logic [2:0] K_VAL_END  = 3'd3;
    localparam logic [2:0] K_STATUS   = 3'd4;

    // String status codes.
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_UNEXP  = 2'd1;
    localparam logic [1:0] ST_SYNTAX = 2'd2;

    // Special characters.
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_L     = 8'h6C;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Whitespace: tab through carriage return, and space.
    function automatic logic is_ws(input logic [7:0] c);
        return ((c >= 8'd9) && (c <= 8'd13)) || (c == CH_SPACE);
    endfunction

    // Lowercase letter of the null keyword at a given position.
    function automatic logic [7:0] null_char(input logic [1:0] idx);
        logic [7:0] ch;
        case (idx)
            2'd0:    ch = CH_N;
            2'd1:    ch = CH_U;
            default: ch = CH_L;
        endcase
        return ch;
    endfunction

    // Builds one result item; the final mark is set later.
    function automatic t_out_beat mk_res(input logic [2:0] kind, input logic [7:0] data,
                                         input logic is_null, input logic [1:0] status);
        t_out_beat r;
        r.kind      = kind;
        r.data      = data;
        r.is_null   = is_null;
        r.status    = status;
        r.final_res = 1'b0;
        return r;
    endfunction

endpackage

// ===== src/htp_parse.sv =====
// ---------------------------------------------------------------------------
// htp_parse: input register and per-byte parse step
// Holds one input beat and the parse state, and decodes the beat combinationally
// into up to three result items.
// ---------------------------------------------------------------------------
module htp_parse
    import htp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in_beat   i_in_beat,
    input  logic       i_room,
    output t_res_push  o_push,
    output t_out_beat  o_res [RES_SLOTS]
);

    logic       r_in_valid;
    t_in_beat   r_in;
    logic [3:0] r_phase;
    logic       r_null_match;
    logic [2:0] r_value_count;

    logic [3:0] n_phase;
    logic       n_null_match;
    logic [2:0] n_value_count;
    logic       commit;
    t_res_cnt   res_cnt;
    t_out_beat  res [RES_SLOTS];

    // The held beat is decoded once the result queue can take three items.
    assign commit     = r_in_valid && i_room;
    assign o_in_ready = !r_in_valid || commit;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_beat;
        end
    end

    // Parse state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_KEY_WAIT;
            r_null_match  <= 1'b1;
            r_value_count <= 3'd0;
        end else if (commit) begin
            r_phase       <= n_phase;
            r_null_match  <= n_null_match;
            r_value_count <= n_value_count;
        end
    end

    // One parse step for the held byte.
    always_comb begin
        logic [3:0] ph;
        logic       nm;
        logic [2:0] vc;
        logic [7:0] c;
        logic       lst;
        logic       stop;
        logic [1:0] st;
        t_res_cnt   cnt;

        ph   = r_phase;
        nm   = r_null_match;
        vc   = r_value_count;
        c    = r_in.byte_req;
        lst  = r_in.last;
        stop = 1'b0;
        st   = ST_UNEXP;
        cnt  = 2'd0;
        for (int k = 0; k < RES_SLOTS; k++) begin
            res[k] = mk_res(K_KEY_BYTE, 8'd0, 1'b0, ST_OK);
        end

        if (ph == PH_DISCARD) begin
            // Skip bytes after an error up to the end of the string.
            if (lst) begin
                ph = PH_KEY_WAIT;
            end
            stop = 1'b1;
        end else begin
            if (ph > PH_DISCARD) begin
                ph = PH_KEY_WAIT;
            end
            case (ph)
                PH_KEY_WAIT: begin
                    if (!is_ws(c)) begin
                        if (c == CH_QUOTE) begin
                            ph = PH_KEY_Q;
                        end else if (c == CH_EQ) begin
                            res[cnt] = mk_res(K_STATUS, 8'd0, 1'b0, ST_SYNTAX);
                            cnt  = cnt + 2'd1;
                            ph   = lst ? PH_KEY_WAIT : PH_DISCARD;
                            stop = 1'b1;
                        end else if (c == CH_BSLASH) begin
                            ph = PH_KEY_U_ESC;
                        end else begin
                            res[cnt] = mk_res(K_KEY_BYTE, c, 1'b0, ST_OK);
                            cnt = cnt + 2'd1;
                            ph  = PH_KEY_U;
                        end
                    end
                end
                PH_KEY_Q: begin
                    if (c == CH_BSLASH) begin
                        ph = PH_KEY_Q_ESC;
                    end else if (c == CH_QUOTE) begin
                        res[cnt] = mk_res(K_KEY_END, 8'd0, 1'b0, ST_OK);
                        cnt = cnt + 2'd1;
                        ph  = PH_EQ;
                    end else begin
                        res[cnt] = mk_res(K_KEY_BYTE, c, 1'b0, ST_OK);
                        cnt = cnt + 2'd1;
                    end
                end
                PH_KEY_Q_ESC: begin
                    res[cnt] = mk_res(K_KEY_BYTE, c, 1'b0, ST_OK);
                    cnt = cnt + 2'd1;
                    ph  = PH_KEY_Q;
                end
                PH_KEY_U: begin
                    if (c == CH_BSLASH) begin
                        ph = PH_KEY_U_ESC;
                    end else if (is_ws(c)) begin
                        res[cnt] = mk_res(K_KEY_END, 8'd0, 1'b0, ST_OK);
                        cnt = cnt + 2'd1;
                        ph  = PH_EQ;
                    end else if (c == CH_EQ) begin
                        res[cnt] = mk_res(K_KEY_END, 8'd0, 1'b0, ST_OK);
                        cnt = cnt + 2'd1;
                        if (lst) begin
                            res[cnt] = mk_res(K_STATUS, 8'd0, 1'b0, ST_UNEXP);
                            cnt  = cnt + 2'd1;
                            ph   = PH_KEY_WAIT;
                            stop = 1'b1;
                        end else begin
                            ph = PH_GT;
                        end
                    end else begin
                        res[cnt] = mk_res(K_KEY_BYTE, c, 1'b0, ST_OK);
                        cnt = cnt + 2'd1;
                    end
                end
                PH_KEY_U_ESC: begin
                    res[cnt] = mk_res(K_KEY_BYTE, c, 1'b0, ST_OK);
                    cnt = cnt + 2'd1;
                    ph  = PH_KEY_U;
                end
                PH_EQ: begin
                    if (!is_ws(c)) begin
                        if (lst) begin
                            res[cnt] = mk_res(K_STATUS, 8'd0, 1'b0, ST_UNEXP);
                            cnt  = cnt + 2'd1;
                            ph   = PH_KEY_WAIT;
                            stop = 1'b1;
                        end else if (c != CH_EQ) begin
                            res[cnt] = mk_res(K_STATUS, 8'd0, 1'b0, ST_SYNTAX);
                            cnt  = cnt + 2'd1;
                            ph   = PH_DISCARD;
                            stop = 1'b1;
                        end else begin
                            ph = PH_GT;
                        end
                    end
                end
                PH_GT: begin
                    if (c != CH_GT) begin
                        res[cnt] = mk_res(K_STATUS, 8'd0, 1'b0, ST_SYNTAX);
                        cnt  = cnt + 2'd1;
                        ph   = lst ? PH_KEY_WAIT : PH_DISCARD;
                        stop = 1'b1;
                    end else begin
                        ph = PH_VAL_WAIT;
                    end
                end
                PH_VAL_WAIT: begin
                    if (!is_ws(c)) begin
                        nm = 1'b1;
                        vc = 3'd0;
                        if (c == CH_QUOTE) begin
                            ph = PH_VAL_Q;
                        end else if (c == CH_BSLASH) begin
                            ph = PH_VAL_U_ESC;
                        end else if (c == CH_COMMA) begin
                            // A value that starts with a comma is empty.
                            res[cnt] = mk_res(K_VAL_END, 8'd0, 1'b0, ST_OK);
                            cnt = cnt + 2'd1;
                            ph  = PH_KEY_WAIT;
                        end else begin
                            if ((c | CH_SPACE) != null_char(vc[1:0])) begin
                                nm = 1'b0;
                            end
                            vc = vc + 3'd1;
                            res[cnt] = mk_res(K_VAL_BYTE, c, 1'b0, ST_OK);
                            cnt = cnt + 2'd1;
                            ph  = PH_VAL_U;
                        end
                    end
                end
                PH_VAL_Q: begin
                    if (c == CH_BSLASH) begin
                        ph = PH_VAL_Q_ESC;
                    end else if (c == CH_QUOTE) begin
                        res[cnt] = mk_res(K_VAL_END, 8'd0, 1'b0, ST_OK);
                        cnt = cnt + 2'd1;
                        ph  = PH_DEL;
                    end else begin
                        res[cnt] = mk_res(K_VAL_BYTE, c, 1'b0, ST_OK);
                        cnt = cnt + 2'd1;
                    end
                end
                PH_VAL_Q_ESC: begin
                    res[cnt] = mk_res(K_VAL_BYTE, c, 1'b0, ST_OK);
                    cnt = cnt + 2'd1;
                    ph  = PH_VAL_Q;
                end
                PH_VAL_U, PH_VAL_U_ESC: begin
                    if (ph == PH_VAL_U && c == CH_BSLASH) begin
                        ph = PH_VAL_U_ESC;
                    end else if (ph == PH_VAL_U && (c == CH_COMMA || is_ws(c))) begin
                        res[cnt] = mk_res(K_VAL_END, 8'd0, nm && (vc == 3'd4), ST_OK);
                        cnt = cnt + 2'd1;
                        ph  = (c == CH_COMMA) ? PH_KEY_WAIT : PH_DEL;
                    end else begin
                        // Track the null keyword, case-insensitive.
                        if (vc < 3'd4) begin
                            if ((c | CH_SPACE) != null_char(vc[1:0])) begin
                                nm = 1'b0;
                            end
                        end else begin
                            nm = 1'b0;
                        end
                        if (vc < 3'd5) begin
                            vc = vc + 3'd1;
                        end
                        res[cnt] = mk_res(K_VAL_BYTE, c, 1'b0, ST_OK);
                        cnt = cnt + 2'd1;
                        ph  = PH_VAL_U;
                    end
                end
                default: begin
                    // Delimiter after a value.
                    if (!is_ws(c)) begin
                        if (c != CH_COMMA) begin
                            res[cnt] = mk_res(K_STATUS, 8'd0, 1'b0, ST_SYNTAX);
                            cnt  = cnt + 2'd1;
                            ph   = lst ? PH_KEY_WAIT : PH_DISCARD;
                            stop = 1'b1;
                        end else begin
                            ph = PH_KEY_WAIT;
                        end
                    end
                end
            endcase
        end

        // Close the string on its last byte.
        if (!stop && lst) begin
            if (ph == PH_KEY_WAIT || ph == PH_DEL) begin
                st = ST_OK;
            end else if (ph == PH_VAL_U) begin
                res[cnt] = mk_res(K_VAL_END, 8'd0, nm && (vc == 3'd4), ST_OK);
                cnt = cnt + 2'd1;
                st  = ST_OK;
            end else if (ph == PH_KEY_U) begin
                res[cnt] = mk_res(K_KEY_END, 8'd0, 1'b0, ST_OK);
                cnt = cnt + 2'd1;
            end
            res[cnt] = mk_res(K_STATUS, 8'd0, 1'b0, st);
            cnt = cnt + 2'd1;
            ph  = PH_KEY_WAIT;
        end

        // Mark the last result of this byte.
        if (cnt != 2'd0) begin
            res[cnt - 2'd1].final_res = 1'b1;
        end

        n_phase       = ph;
        n_null_match  = nm;
        n_value_count = vc;
        res_cnt       = cnt;
    end

    assign o_push.push = commit;
    assign o_push.cnt  = res_cnt;
    assign o_res       = res;

endmodule

// ===== src/htp_out_queue.sv =====
// ---------------------------------------------------------------------------
// htp_out_queue: result register queue
// Four-entry queue that takes up to three result items in one cycle and
// delivers one result beat per cycle while the output is ready.
// ---------------------------------------------------------------------------
module htp_out_queue
    import htp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_res_push  i_push,
    input  t_out_beat  i_res [RES_SLOTS],
    output logic       o_room,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_beat  o_out_beat
);

    localparam int unsigned DEPTH = 4;

    t_out_beat  r_mem [DEPTH];
    logic [1:0] r_wr_ptr;
    logic [1:0] r_rd_ptr;
    logic [2:0] r_count;

    logic [1:0] n_wr_ptr;
    logic [1:0] n_rd_ptr;
    logic [2:0] n_count;
    logic       pop;
    t_res_cnt   push_cnt;

    // Room for a full burst of three results.
    assign o_room      = (r_count <= 3'd1);
    assign o_out_valid = (r_count != 3'd0);
    assign o_out_beat  = r_mem[r_rd_ptr];
    assign pop         = o_out_valid && i_out_ready;
    assign push_cnt    = i_push.push ? i_push.cnt : 2'd0;

    // Pointer and fill arithmetic.
    always_comb begin
        n_wr_ptr = r_wr_ptr + push_cnt;
        n_rd_ptr = r_rd_ptr + {1'b0, pop};
        n_count  = r_count + {1'b0, push_cnt} - {2'b00, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 2'd0;
            r_rd_ptr <= 2'd0;
            r_count  <= 3'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage writes for the new results.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < RES_SLOTS; k++) begin
            if (2'(k) < push_cnt) begin
                r_mem[2'(r_wr_ptr + 2'(k))] <= i_res[k];
            end
        end
    end

endmodule

// ===== src/hstore_text_parser_core.sv =====
// ---------------------------------------------------------------------------
// hstore_text_parser_core: streaming key/value text parser
// Decodes key => value text one byte per beat into key, value, end and
// status results.
// ---------------------------------------------------------------------------
// The block accepts one text byte per cycle while it is not stalled. A byte
// is held in the input register, where it is decoded into zero to three
// results, which are written at once into a four-entry result queue that
// delivers one result beat per cycle while the output is ready. A byte moves
// on from the input register only while the queue holds at most one result,
// so sustained throughput is one byte per cycle as long as bytes average no
// more than one result each and the output is ready; bytes that give two or
// three results stall the input while the queue drains. An accepted byte
// passes the input register and then the result queue. Every string ends in a
// status beat, and the final_res bit marks the last result caused by each byte.
module hstore_text_parser_core
    import htp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_beat  i_in_beat,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_beat o_out_beat
);

    logic      room;
    t_res_push push;
    t_out_beat res [RES_SLOTS];

    // Byte decode stage.
    htp_parse u_parse (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_beat  (i_in_beat),
        .i_room     (room),
        .o_push     (push),
        .o_res      (res)
    );

    // Result queue.
    htp_out_queue u_out_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_res       (res),
        .o_room      (room),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_beat  (o_out_beat)
    );

endmodule

// ===== sim/tb_hstore_text_parser_core.sv =====
// ---------------------------------------------------------------------------
// tb_hstore_text_parser_core: self-checking bench for the key/value parser
// Feeds text strings one byte per beat, predicts every result beat with an
// in-bench parser model and compares the output stream field by field.
// ---------------------------------------------------------------------------
module tb_hstore_text_parser_core;
    import htp_pkg::*;

    localparam int IDLE_PCT    = 28;
    localparam int STALL_LIMIT = 2000;
    localparam int END_CYCLES  = 12;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_beat  in_beat   = '0;
    logic      out_ready = 1'b0;
    logic      in_ready;
    logic      out_valid;
    t_out_beat out_beat;

    // Parser state as the bench predicts it.
    logic [3:0] pred_phase   = PH_KEY_WAIT;
    logic       pred_null_ok = 1'b1;
    logic [2:0] pred_val_len = 3'd0;

    t_out_beat  byte_results[$];
    t_out_beat  expected_results[$];
    logic [7:0] text_buf[$];
    t_out_beat  want_beat;

    bit no_idle        = 1'b0;
    int errors         = 0;
    int strings_sent   = 0;
    int bytes_sent     = 0;
    int results_seen   = 0;
    int null_flags     = 0;
    int error_statuses = 0;
    int stall_cycles   = 0;

    hstore_text_parser_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_beat   (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_beat  (out_beat)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Parser prediction
    // ------------------------------------------------------------------

    function automatic logic is_blank(input logic [7:0] c);
        case (c)
            8'd9, 8'd10, 8'd11, 8'd12, 8'd13, CH_SPACE: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic void queue_result(input logic [2:0] kind, input logic [7:0] data,
                                         input logic nul, input logic [1:0] st);
        t_out_beat r;
        r.kind      = kind;
        r.data      = data;
        r.is_null   = nul;
        r.status    = st;
        r.final_res = 1'b0;
        byte_results.push_back(r);
    endfunction

    // A content byte of an unquoted value also tracks the null keyword.
    function automatic void take_value_char(input logic [7:0] c);
        logic [7:0] letter;
        case (pred_val_len)
            3'd0:    letter = CH_N;
            3'd1:    letter = CH_U;
            default: letter = CH_L;
        endcase
        if (pred_val_len >= 3'd4 || (c | 8'h20) != letter) pred_null_ok = 1'b0;
        if (pred_val_len < 3'd5) pred_val_len = pred_val_len + 3'd1;
        queue_result(K_VAL_BYTE, c, 1'b0, ST_OK);
    endfunction

    function automatic void close_value();
        queue_result(K_VAL_END, 8'd0, pred_null_ok && (pred_val_len == 3'd4), ST_OK);
    endfunction

    // An error ends the string unless more bytes follow, which are then dropped.
    function automatic void raise_error(input logic [1:0] st, input logic is_last);
        queue_result(K_STATUS, 8'd0, 1'b0, st);
        pred_phase = is_last ? PH_KEY_WAIT : PH_DISCARD;
    endfunction

    function automatic void predict_byte(input logic [7:0] c, input logic is_last);
        logic [3:0] ph;
        logic [1:0] st;
        logic       blank;
        logic       failed;
        t_out_beat  tail;
        byte_results.delete();
        blank  = is_blank(c);
        failed = 1'b0;
        if (pred_phase == PH_DISCARD) begin
            if (is_last) pred_phase = PH_KEY_WAIT;
            return;
        end
        ph = (pred_phase > PH_DISCARD) ? PH_KEY_WAIT : pred_phase;
        case (ph)
            PH_KEY_WAIT: begin
                if (!blank) begin
                    if (c == CH_QUOTE) begin
                        ph = PH_KEY_Q;
                    end else if (c == CH_EQ) begin
                        raise_error(ST_SYNTAX, is_last);
                        failed = 1'b1;
                    end else if (c == CH_BSLASH) begin
                        ph = PH_KEY_U_ESC;
                    end else begin
                        queue_result(K_KEY_BYTE, c, 1'b0, ST_OK);
                        ph = PH_KEY_U;
                    end
                end
            end
            PH_KEY_Q: begin
                if (c == CH_BSLASH) begin
                    ph = PH_KEY_Q_ESC;
                end else if (c == CH_QUOTE) begin
                    queue_result(K_KEY_END, 8'd0, 1'b0, ST_OK);
                    ph = PH_EQ;
                end else begin
                    queue_result(K_KEY_BYTE, c, 1'b0, ST_OK);
                end
            end
            PH_KEY_Q_ESC: begin
                queue_result(K_KEY_BYTE, c, 1'b0, ST_OK);
                ph = PH_KEY_Q;
            end
            PH_KEY_U: begin
                if (c == CH_BSLASH) begin
                    ph = PH_KEY_U_ESC;
                end else if (blank) begin
                    queue_result(K_KEY_END, 8'd0, 1'b0, ST_OK);
                    ph = PH_EQ;
                end else if (c == CH_EQ) begin
                    queue_result(K_KEY_END, 8'd0, 1'b0, ST_OK);
                    if (is_last) begin
                        raise_error(ST_UNEXP, 1'b1);
                        failed = 1'b1;
                    end else begin
                        ph = PH_GT;
                    end
                end else begin
                    queue_result(K_KEY_BYTE, c, 1'b0, ST_OK);
                end
            end
            PH_KEY_U_ESC: begin
                queue_result(K_KEY_BYTE, c, 1'b0, ST_OK);
                ph = PH_KEY_U;
            end
            PH_EQ: begin
                if (!blank) begin
                    if (is_last) begin
                        raise_error(ST_UNEXP, 1'b1);
                        failed = 1'b1;
                    end else if (c != CH_EQ) begin
                        raise_error(ST_SYNTAX, 1'b0);
                        failed = 1'b1;
                    end else begin
                        ph = PH_GT;
                    end
                end
            end
            PH_GT: begin
                if (c != CH_GT) begin
                    raise_error(ST_SYNTAX, is_last);
                    failed = 1'b1;
                end else begin
                    ph = PH_VAL_WAIT;
                end
            end
            PH_VAL_WAIT: begin
                if (!blank) begin
                    pred_null_ok = 1'b1;
                    pred_val_len = 3'd0;
                    if (c == CH_QUOTE) begin
                        ph = PH_VAL_Q;
                    end else if (c == CH_BSLASH) begin
                        ph = PH_VAL_U_ESC;
                    end else if (c == CH_COMMA) begin
                        close_value();
                        ph = PH_KEY_WAIT;
                    end else begin
                        take_value_char(c);
                        ph = PH_VAL_U;
                    end
                end
            end
            PH_VAL_Q: begin
                if (c == CH_BSLASH) begin
                    ph = PH_VAL_Q_ESC;
                end else if (c == CH_QUOTE) begin
                    queue_result(K_VAL_END, 8'd0, 1'b0, ST_OK);
                    ph = PH_DEL;
                end else begin
                    queue_result(K_VAL_BYTE, c, 1'b0, ST_OK);
                end
            end
            PH_VAL_Q_ESC: begin
                queue_result(K_VAL_BYTE, c, 1'b0, ST_OK);
                ph = PH_VAL_Q;
            end
            PH_VAL_U: begin
                if (c == CH_BSLASH) begin
                    ph = PH_VAL_U_ESC;
                end else if (c == CH_COMMA) begin
                    close_value();
                    ph = PH_KEY_WAIT;
                end else if (blank) begin
                    close_value();
                    ph = PH_DEL;
                end else begin
                    take_value_char(c);
                end
            end
            PH_VAL_U_ESC: begin
                take_value_char(c);
                ph = PH_VAL_U;
            end
            default: begin
                // After a value only blanks and a comma may follow.
                if (!blank) begin
                    if (c != CH_COMMA) begin
                        raise_error(ST_SYNTAX, is_last);
                        failed = 1'b1;
                    end else begin
                        ph = PH_KEY_WAIT;
                    end
                end
            end
        endcase

        // End of string closes what is open and reports the status.
        if (!failed) begin
            pred_phase = ph;
            if (is_last) begin
                st = ST_UNEXP;
                if (ph == PH_KEY_WAIT || ph == PH_DEL) begin
                    st = ST_OK;
                end else if (ph == PH_VAL_U) begin
                    close_value();
                    st = ST_OK;
                end else if (ph == PH_KEY_U) begin
                    queue_result(K_KEY_END, 8'd0, 1'b0, ST_OK);
                end
                queue_result(K_STATUS, 8'd0, 1'b0, st);
                pred_phase = PH_KEY_WAIT;
            end
        end

        // Mark the last result of this byte and hand all of them over.
        if (byte_results.size() > 0) begin
            tail = byte_results.pop_back();
            tail.final_res = 1'b1;
            byte_results.push_back(tail);
        end
        foreach (byte_results[i]) expected_results.push_back(byte_results[i]);
    endfunction

    // ------------------------------------------------------------------
    // Text generation
    // ------------------------------------------------------------------

    function automatic logic [7:0] pick_content();
        logic [7:0] c;
        if ($urandom_range(1) == 0) begin
            c = 8'($urandom_range(25));
            c = c + 8'h61;
            if ($urandom_range(1) == 0) c = c & 8'hDF;
        end else begin
            c = 8'($urandom_range(255));
        end
        return c;
    endfunction

    function automatic logic [7:0] pick_blank();
        logic [7:0] c;
        if ($urandom_range(2) == 0) begin
            c = 8'($urandom_range(4));
            c = c + 8'd9;
        end else begin
            c = CH_SPACE;
        end
        return c;
    endfunction

    function automatic logic [7:0] pick_special();
        logic [7:0] c;
        case ($urandom_range(7))
            0:       c = CH_QUOTE;
            1:       c = CH_BSLASH;
            2:       c = CH_EQ;
            3:       c = CH_GT;
            4:       c = CH_COMMA;
            5:       c = pick_blank();
            6:       c = CH_N;
            default: c = 8'($urandom_range(255));
        endcase
        return c;
    endfunction

    function automatic logic needs_escape(input logic [7:0] c);
        return is_blank(c) || c == CH_EQ || c == CH_COMMA || c == CH_QUOTE || c == CH_BSLASH;
    endfunction

    function automatic void append_blanks();
        if ($urandom_range(99) < 30) begin
            repeat ($urandom_range(1, 2)) text_buf.push_back(pick_blank());
        end
    endfunction

    // One key or value; the null word is spelled in random case.
    function automatic void append_word(input bit quoted, input int len, input bit null_word);
        logic [7:0] c;
        bit         esc;
        if (quoted) text_buf.push_back(CH_QUOTE);
        for (int i = 0; i < len; i++) begin
            if (null_word) begin
                c = (i == 0) ? CH_N : (i == 1) ? CH_U : CH_L;
                if ($urandom_range(1) == 0) c = c & 8'hDF;
            end else begin
                c = pick_content();
            end
            if (quoted) esc = (c == CH_QUOTE) || (c == CH_BSLASH);
            else esc = needs_escape(c);
            if ($urandom_range(9) == 0) esc = 1'b1;
            if (esc) text_buf.push_back(CH_BSLASH);
            text_buf.push_back(c);
        end
        if (quoted) text_buf.push_back(CH_QUOTE);
    endfunction

    function automatic void build_pairs();
        int pairs;
        int sel;
        bit quoted;
        bit empty_val;
        text_buf.delete();
        empty_val = 1'b0;
        pairs = $urandom_range(1, 3);
        for (int p = 0; p < pairs; p++) begin
            if (p > 0 && !empty_val) text_buf.push_back(CH_COMMA);
            append_blanks();
            quoted = ($urandom_range(1) == 0);
            append_word(quoted, quoted ? $urandom_range(0, 3) : $urandom_range(1, 3), 1'b0);
            append_blanks();
            text_buf.push_back(CH_EQ);
            text_buf.push_back(CH_GT);
            append_blanks();
            empty_val = 1'b0;
            sel = $urandom_range(9);
            if (sel < 3) begin
                append_word(1'b1, $urandom_range(0, 4), 1'b0);
            end else if (sel < 7) begin
                append_word(1'b0, $urandom_range(1, 5), 1'b0);
            end else if (sel < 9) begin
                append_word($urandom_range(3) == 0, 4, 1'b1);
            end else begin
                text_buf.push_back(CH_COMMA);
                empty_val = 1'b1;
            end
            if (!empty_val) append_blanks();
        end
        if (!empty_val && $urandom_range(1) == 0) text_buf.push_back(CH_COMMA);
    endfunction

    // A well-formed string cut short or with one byte replaced.
    function automatic void build_broken();
        int keep;
        int idx;
        build_pairs();
        if ($urandom_range(1) == 0 && text_buf.size() > 1) begin
            keep = $urandom_range(1, text_buf.size() - 1);
            while (text_buf.size() > keep) void'(text_buf.pop_back());
        end else begin
            idx = $urandom_range(0, text_buf.size() - 1);
            text_buf[idx] = pick_special();
        end
    endfunction

    function automatic void build_noise();
        text_buf.delete();
        repeat ($urandom_range(1, 6)) begin
            text_buf.push_back(($urandom_range(1) == 0) ? pick_special() : pick_content());
        end
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Sends one byte beat, with a random gap first, and predicts its results.
    task automatic send_byte(input logic [7:0] c, input logic is_last);
        int       gap;
        t_in_beat beat;
        gap = 0;
        if (!no_idle) begin
            while ($urandom_range(99) < IDLE_PCT) gap++;
        end
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        beat.byte_req = c;
        beat.last     = is_last;
        in_valid <= 1'b1;
        in_beat  <= beat;
        do @(posedge clk); while (!in_ready);
        predict_byte(c, is_last);
        bytes_sent++;
    endtask

    task automatic send_text();
        for (int i = 0; i < text_buf.size(); i++) begin
            send_byte(text_buf[i], i == text_buf.size() - 1);
        end
        strings_sent++;
    endtask

    task automatic send_literal(input string s);
        text_buf.delete();
        for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
        send_text();
    endtask

    // Holds the input back until every predicted result has arrived.
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (expected_results.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Unquoted key ended by '=', mixed-case null value and a trailing comma.
    task automatic test_plain_pair();
        send_literal("k=>NuLl,");
    endtask

    // A leading '=' is a syntax error; the rest of the string is dropped.
    task automatic test_leading_equals();
        send_literal("=x");
    endtask

    // Strings that end inside a key, after a key, and inside an open quote.
    task automatic test_open_endings();
        send_literal("a");
        send_literal("a=");
        send_literal("\"");
    endtask

    // A quoted key whose '=' is not followed by '>'.
    task automatic test_separator_error();
        send_literal("\"q\"=x,");
    endtask

    // Leading backslashes on key and value carrying the lowest and highest byte.
    task automatic test_escaped_extremes();
        text_buf.delete();
        text_buf.push_back(CH_BSLASH);
        text_buf.push_back(8'h00);
        text_buf.push_back(CH_EQ);
        text_buf.push_back(CH_GT);
        text_buf.push_back(CH_BSLASH);
        text_buf.push_back(8'hFF);
        send_text();
    endtask

    // Mostly well-formed strings with random content, some broken, some noise.
    task automatic test_random_text(input int n_items);
        int start;
        int sel;
        start = bytes_sent;
        while (bytes_sent - start < n_items) begin
            sel = $urandom_range(99);
            if (sel < 70) build_pairs();
            else if (sel < 85) build_broken();
            else build_noise();
            send_text();
        end
    endtask

    task automatic test_back_to_back(input int n_items);
        no_idle = 1'b1;
        test_random_text(n_items);
        no_idle = 1'b0;
    endtask

    task automatic test_drain_pause();
        build_pairs();
        send_text();
        drain_results();
        build_pairs();
        send_text();
    endtask

    // ------------------------------------------------------------------
    // Output side: random back-pressure and the result checker
    // ------------------------------------------------------------------

    always @(posedge clk) begin
        out_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end

    task automatic field_err(input string name, input int want, input int got);
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    endtask

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            results_seen++;
            if (out_beat.kind == K_VAL_END && out_beat.is_null) null_flags++;
            if (out_beat.kind == K_STATUS && out_beat.status != ST_OK) error_statuses++;
            if (expected_results.size() == 0) begin
                errors++;
                $display("%0t: result beat with none expected, expected none, actual %h",
                         $time, out_beat);
            end else begin
                want_beat = expected_results.pop_front();
                if (out_beat.kind !== want_beat.kind)
                    field_err("kind", int'(want_beat.kind), int'(out_beat.kind));
                if (out_beat.data !== want_beat.data)
                    field_err("data", int'(want_beat.data), int'(out_beat.data));
                if (out_beat.is_null !== want_beat.is_null)
                    field_err("is_null", int'(want_beat.is_null), int'(out_beat.is_null));
                if (out_beat.status !== want_beat.status)
                    field_err("status", int'(want_beat.status), int'(out_beat.status));
                if (out_beat.final_res !== want_beat.final_res)
                    field_err("final_res", int'(want_beat.final_res),
                              int'(out_beat.final_res));
            end
        end
    end

    // Watchdog: counts cycles in which no beat moves on either side.
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
    end

    initial begin
        while (stall_cycles < STALL_LIMIT) @(posedge clk);
        $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        test_plain_pair();
        test_leading_equals();
        test_open_endings();
        test_separator_error();
        test_escaped_extremes();
        test_random_text(20);
        test_drain_pause();
        test_back_to_back(30);
        test_random_text(20);
        drain_results();
        repeat (END_CYCLES) @(posedge clk);
        $display("Run covered %0d strings in %0d byte beats, giving %0d result beats.",
                 strings_sent, bytes_sent, results_seen);
        $display("Seen %0d null-flagged values and %0d strings ending in an error status.",
                 null_flags, error_statuses);
        if (errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
